>>> hw/rtl/sha256_stream_hasher_macros.svh
// Assertion helpers
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
`ifndef ASSERT_OFF
`define SHS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SHS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define SHS_ASSERT(lbl, clk, rst_n, prop)
`define SHS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hw/rtl/shs_pkg.sv
`timescale 1ns / 1ps
package shs_pkg;

  typedef enum logic [1:0] {
    BSEL_DATA = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      shift_en;
    byte_sel_t byte_sel;
    logic      count_inc;
    logic      latch_len;
    logic      round_init;
    logic      round_en;
    logic      chain_add;
    logic      chain_init;
    logic      out_adv;
  } shs_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
    logic       round_last;
    logic       word_last;
  } shs_stat_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [5:0] POS_LAST = 6'd63;
  localparam logic [5:0] POS_LEN  = 6'd55;
  localparam logic [7:0] PAD_BYTE = 8'h80;

endpackage

>>> hw/rtl/sha256_stream_hasher.sv
`timescale 1ns / 1ps
// SHA-256 over a byte stream. One byte is taken per cycle while a block fills; the 64th
// byte of a block starts the rounds and then the chaining step, during which input is
// held off. At the end of a message, padding and the length field are written one byte
// per cycle and the final block is then compressed; when the tail leaves fewer than 9
// free bytes, the padded block is compressed first and zero and length bytes then fill
// the final block. The eight digest words then go out as eight beats, word 0 first,
// out_tlast on word 7, with input held off until the last one is taken. The hasher then
// restarts from the initial hash.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // is_last
  input  logic        in_tuser,   // empty_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        out_tlast   // last_word
);

  shs_pkg::shs_cmd_t  cmd;
  shs_pkg::shs_stat_t stat;
  logic [31:0] digest_word;
  logic [2:0]  word_index;

  shs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  shs_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .digest_word (digest_word),
    .word_index  (word_index)
  );

  assign out_tdata = {5'd0, word_index, digest_word};
  assign out_tlast = stat.word_last;

endmodule

>>> hw/rtl/shs_datapath.sv
`timescale 1ns / 1ps
module shs_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        data_byte,
  input  shs_pkg::shs_cmd_t cmd,
  output shs_pkg::shs_stat_t stat,
  output logic [31:0]       digest_word,
  output logic [2:0]        word_index
);

  logic [31:0] win_r [16];
  logic [31:0] win_nxt [16];
  logic [31:0] var_r [8];
  logic [31:0] var_nxt [8];
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [63:0] count_r, count_nxt;
  logic [63:0] len_r, len_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  in_byte;
  logic [31:0] s0, s1, new_w, bs0, bs1, ch, maj, t1, t2;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    case (cmd.byte_sel)
      shs_pkg::BSEL_DATA: in_byte = data_byte;
      shs_pkg::BSEL_PAD:  in_byte = shs_pkg::PAD_BYTE;
      shs_pkg::BSEL_ZERO: in_byte = 8'h00;
      shs_pkg::BSEL_LEN:  in_byte = len_r[63:56];
      default:            in_byte = 8'h00;
    endcase
  end

  always_comb begin
    s0    = rotr(win_r[1], 7) ^ rotr(win_r[1], 18) ^ (win_r[1] >> 3);
    s1    = rotr(win_r[14], 17) ^ rotr(win_r[14], 19) ^ (win_r[14] >> 10);
    new_w = s1 + win_r[9] + s0 + win_r[0];
    bs1   = rotr(var_r[4], 6) ^ rotr(var_r[4], 11) ^ rotr(var_r[4], 25);
    ch    = (var_r[4] & var_r[5]) ^ (~var_r[4] & var_r[6]);
    t1    = var_r[7] + bs1 + ch + shs_pkg::ROUND_K[rnd_r] + win_r[0];
    bs0   = rotr(var_r[0], 2) ^ rotr(var_r[0], 13) ^ rotr(var_r[0], 22);
    maj   = (var_r[0] & var_r[1]) ^ (var_r[0] & var_r[2]) ^ (var_r[1] & var_r[2]);
    t2    = bs0 + maj;
  end

  always_comb begin
    win_nxt   = win_r;
    var_nxt   = var_r;
    chain_nxt = chain_r;
    count_nxt = count_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    rnd_nxt   = rnd_r;
    idx_nxt   = idx_r;
    if (cmd.shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = {win_r[i][23:0], win_r[i+1][31:24]};
      end
      win_nxt[15] = {win_r[15][23:0], in_byte};
      pos_nxt     = pos_r + 6'd1;
    end
    if (cmd.count_inc) count_nxt = count_r + 64'd1;
    if (cmd.latch_len) begin
      len_nxt = {count_r[60:0], 3'b000};
    end else if (cmd.byte_sel == shs_pkg::BSEL_LEN && cmd.shift_en) begin
      len_nxt = {len_r[55:0], 8'h00};
    end
    if (cmd.round_init) begin
      var_nxt = chain_r;
      rnd_nxt = 6'd0;
    end
    if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) win_nxt[i] = win_r[i+1];
      win_nxt[15] = new_w;
      var_nxt[7]  = var_r[6];
      var_nxt[6]  = var_r[5];
      var_nxt[5]  = var_r[4];
      var_nxt[4]  = var_r[3] + t1;
      var_nxt[3]  = var_r[2];
      var_nxt[2]  = var_r[1];
      var_nxt[1]  = var_r[0];
      var_nxt[0]  = t1 + t2;
      rnd_nxt     = rnd_r + 6'd1;
    end
    if (cmd.chain_add) begin
      for (int i = 0; i < 8; i++) chain_nxt[i] = chain_r[i] + var_r[i];
    end
    if (cmd.out_adv) idx_nxt = idx_r + 3'd1;
    if (cmd.chain_init) begin
      chain_nxt = shs_pkg::IV;
      count_nxt = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= shs_pkg::IV;
      count_r <= 64'd0;
      pos_r   <= 6'd0;
      rnd_r   <= 6'd0;
      idx_r   <= 3'd0;
    end else begin
      chain_r <= chain_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    var_r <= var_nxt;
    len_r <= len_nxt;
  end

  assign stat.pos        = pos_r;
  assign stat.round_last = (rnd_r == 6'd63);
  assign stat.word_last  = (idx_r == 3'd7);
  assign digest_word     = chain_r[idx_r];
  assign word_index      = idx_r;

endmodule

>>> hw/rtl/shs_ctrl.sv
`timescale 1ns / 1ps
`include "sha256_stream_hasher_macros.svh"
module shs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tlast,
  input  logic               in_tuser,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  shs_pkg::shs_stat_t stat,
  output shs_pkg::shs_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LEN   = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE = 2'd0,
    RET_PAD  = 2'd1,
    RET_OUT  = 2'd2
  } ret_t;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;
  logic   first_r, first_nxt;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    first_nxt  = first_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            first_nxt = 1'b1;
            state_nxt = S_PAD;
          end else begin
            cmd.shift_en  = 1'b1;
            cmd.byte_sel  = shs_pkg::BSEL_DATA;
            cmd.count_inc = 1'b1;
            first_nxt     = 1'b1;
            if (stat.pos == shs_pkg::POS_LAST) begin
              cmd.round_init = 1'b1;
              state_nxt      = S_ROUND;
              ret_nxt        = in_tlast ? RET_PAD : RET_IDLE;
            end else if (in_tlast) begin
              state_nxt = S_PAD;
            end
          end
        end
      end
      S_PAD: begin
        cmd.shift_en  = 1'b1;
        cmd.byte_sel  = first_r ? shs_pkg::BSEL_PAD : shs_pkg::BSEL_ZERO;
        cmd.latch_len = first_r;
        first_nxt     = 1'b0;
        if (stat.pos == shs_pkg::POS_LAST) begin
          cmd.round_init = 1'b1;
          state_nxt      = S_ROUND;
          ret_nxt        = RET_PAD;
        end else if (stat.pos == shs_pkg::POS_LEN) begin
          state_nxt = S_LEN;
        end
      end
      S_LEN: begin
        cmd.shift_en = 1'b1;
        cmd.byte_sel = shs_pkg::BSEL_LEN;
        if (stat.pos == shs_pkg::POS_LAST) begin
          cmd.round_init = 1'b1;
          state_nxt      = S_ROUND;
          ret_nxt        = RET_OUT;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (stat.round_last) state_nxt = S_ADD;
      end
      S_ADD: begin
        cmd.chain_add = 1'b1;
        case (ret_r)
          RET_IDLE: state_nxt = S_IDLE;
          RET_PAD:  state_nxt = S_PAD;
          RET_OUT:  state_nxt = S_OUT;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.out_adv = 1'b1;
          if (stat.word_last) begin
            cmd.chain_init = 1'b1;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= RET_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      first_r <= first_nxt;
    end
  end

  `SHS_ASSERT(a_onehot, clk, rst_n, $onehot(state_r))
  `SHS_ASSERT(a_full_blk, clk, rst_n, (in_tvalid && in_tready && !in_tuser && stat.pos == shs_pkg::POS_LAST) |=> (state_r == S_ROUND))
  `SHS_ASSERT(a_add, clk, rst_n, (state_r == S_ROUND && stat.round_last) |=> (state_r == S_ADD))
  `SHS_ASSERT(a_out_done, clk, rst_n, (out_tvalid && out_tready && stat.word_last) |=> (state_r == S_IDLE && stat.pos == 6'd0))
  `SHS_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_tready && out_tvalid)

endmodule

>>> test/sha256_digest_checker.sv
`timescale 1ns / 1ps
module sha256_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_words
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain [8];
  logic [7:0]   blk [64];
  logic [63:0]  msg_bytes;
  digest_beat_t digest_q[$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic absorb_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    v = chain;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + shs_pkg::ROUND_K[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic close_message();
    int unsigned rem;
    logic [63:0] bits;
    rem = msg_bytes[5:0];
    bits = msg_bytes << 3;
    blk[rem] = shs_pkg::PAD_BYTE;
    for (int i = rem + 1; i < 64; i++) blk[i] = 8'h00;
    if (rem > 55) begin
      absorb_block();
      for (int i = 0; i < 56; i++) blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) blk[63-i] = bits[8*i +: 8];
    absorb_block();
    for (int i = 0; i < 8; i++)
      digest_q.push_back('{chain[i], 3'(i), i == 7});
    chain = shs_pkg::IV;
    msg_bytes = '0;
  endtask

  task automatic take_byte(logic [7:0] b, logic last, logic empty);
    if (empty) begin
      close_message();
    end else begin
      blk[msg_bytes[5:0]] = b;
      msg_bytes++;
      if (msg_bytes[5:0] == 6'd0) absorb_block();
      if (last) close_message();
    end
  endtask

  digest_beat_t got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      chain = shs_pkg::IV;
      msg_bytes = '0;
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[31:0], out_tdata[34:32], out_tlast};
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest beat %h", $time, got);
          fail_count++;
        end else begin
          want = digest_q.pop_front();
          if (got.word !== want.word || got.index !== want.index
              || got.last !== want.last || out_tdata[39:35] !== 5'd0) begin
            $display("%0t: expected word %h index %0d last %0b, got %h %0d %0b",
                     $time, want.word, want.index, want.last,
                     out_tdata[31:0], out_tdata[34:32], out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast, in_tuser);
    end
    pending_words = digest_q.size();
  end
endmodule

>>> test/tb_sha256_stream_hasher.sv
`timescale 1ns / 1ps
module tb_sha256_stream_hasher;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;
  int          fail_count;
  int          pending_words;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_off = 0;

  always #1 clk = ~clk;

  sha256_stream_hasher u_top (.*);

  sha256_digest_checker u_chk (.*);

  task automatic send_beat(logic [7:0] b, logic last, logic empty);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    in_tuser <= empty;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit end_empty);
    for (int i = 0; i < len; i++)
      send_beat(8'($urandom_range(255)), !end_empty && i == len - 1, 1'b0);
    if (end_empty || len == 0)
      send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_tready <= $urandom_range(99) >= recv_idle;
    end
  end

  initial begin
    #2000000;
    $display("sha256_stream_hasher test failed");
    $finish;
  end

  initial begin
    int sent;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h61, 1'b0, 1'b0);
    send_beat(8'h62, 1'b0, 1'b1);
    send_message(55, 0);
    send_message(56, 0);
    send_message(64, 0);
    send_message(64, 1);
    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 16 : phase == 1 ? 71 : 0;
      recv_idle = phase == 0 ? 71 : phase == 1 ? 16 : 0;
      if (phase == 2) hold_off = 400;
      while (sent < 50 * (phase + 1)) begin
        int len;
        bit end_empty;
        len = $urandom_range(3) == 0 ? $urandom_range(50, 70) : $urandom_range(0, 12);
        end_empty = $urandom_range(3) == 0;
        send_message(len, end_empty);
        sent += len + ((end_empty || len == 0) ? 1 : 0);
      end
    end
    in_tvalid <= 1'b0;
    recv_idle = 0;
    while (pending_words != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_count == 0) begin
      $display("sha256_stream_hasher test passed");
    end else begin
      $display("sha256_stream_hasher test failed");
    end
    $finish;
  end
endmodule
